// File: rtl/assert_macros.svh
// Assertion macros shared by the queue RTL.
// Included by files that carry concurrent assertions; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed: invariant");
// Property where a condition implies a consequence in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst, cond, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
      else $error("assertion failed: implication");
`else
`define ASSERT_ALWAYS(label, clk, rst, expr)
`define ASSERT_IMPLIES(label, clk, rst, cond, cons)
`endif
`endif

// File: rtl/spq_pkg.sv
// Shared types and constants of the strict priority packet queue.
// No dependencies; used by the channel interfaces, the top level and the simulation files.
`timescale 1ns / 1ps

package spq_pkg;

   // Default sizing, handed to the top level parameters.
   localparam int TOTAL_SLOTS_DEF = 256;
   localparam int HANDLE_BITS_DEF = 16;

   // Fixed field widths.
   localparam int CLASS_COUNT = 4;
   localparam int CLASS_BITS  = 2;
   localparam int OPCODE_BITS = 3;
   localparam int BYTES_BITS  = 16;
   localparam int CAP_BITS    = 9;
   localparam int COUNT_BITS  = 8;
   localparam int STAT_BITS   = 48;

   // Register map, as word index.
   localparam logic CSR_SLOT_BUDGET = 1'b0;
   localparam logic [CAP_BITS-1:0] SLOT_BUDGET_RESET = 9'd256;

   // Request operation codes.
   typedef enum logic [OPCODE_BITS-1:0] {
      OP_ENQUEUE = 3'd0,
      OP_DEQUEUE = 3'd1,
      OP_PEEK    = 3'd2,
      OP_FLUSH   = 3'd3,
      OP_CLEAR   = 3'd4
   } opcode_type;

   // Sequencer states, one-hot.
   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_DONE = 2'b10
   } state_type;

endpackage

// File: rtl/spq_req_if.sv
// Request channel of the strict priority packet queue.
// Depends on spq_pkg for the field widths.
`timescale 1ns / 1ps

interface spq_req_if #(
   parameter int HANDLE_BITS = spq_pkg::HANDLE_BITS_DEF
);
   import spq_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [OPCODE_BITS-1:0] opcode;
   logic [HANDLE_BITS-1:0] packet_handle;
   logic [CLASS_BITS-1:0]  priority_req;
   logic [BYTES_BITS-1:0]  payload_bytes;

   modport source (output valid, opcode, packet_handle, priority_req, payload_bytes,
                   input ready);
   modport sink   (input valid, opcode, packet_handle, priority_req, payload_bytes,
                   output ready);
endinterface

// File: rtl/spq_rsp_if.sv
// Result channel of the strict priority packet queue.
// Depends on spq_pkg for the field widths.
`timescale 1ns / 1ps

interface spq_rsp_if #(
   parameter int HANDLE_BITS = spq_pkg::HANDLE_BITS_DEF
);
   import spq_pkg::*;

   logic                   valid;
   logic                   ready;
   logic                   ok;
   logic [HANDLE_BITS-1:0] out_handle;
   logic [CLASS_BITS-1:0]  out_priority;
   logic [BYTES_BITS-1:0]  out_payload_bytes;
   logic [CAP_BITS-1:0]    current_packets;
   logic [CAP_BITS-1:0]    peak_packets;
   logic [STAT_BITS-1:0]   enqueued_count;
   logic [STAT_BITS-1:0]   dequeued_count;
   logic [STAT_BITS-1:0]   dropped_count;
   logic [STAT_BITS-1:0]   bytes_in;
   logic [STAT_BITS-1:0]   bytes_out;
   logic                   all_full;

   modport source (output valid, ok, out_handle, out_priority, out_payload_bytes,
                          current_packets, peak_packets, enqueued_count,
                          dequeued_count, dropped_count, bytes_in, bytes_out, all_full,
                   input ready);
   modport sink   (input valid, ok, out_handle, out_priority, out_payload_bytes,
                         current_packets, peak_packets, enqueued_count,
                         dequeued_count, dropped_count, bytes_in, bytes_out, all_full,
                   output ready);
endinterface

// File: rtl/spq_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module spq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and registered read; read data holds until the next read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/strict_priority_packet_queue.sv
// Strict priority packet queue: four descriptor FIFOs, one per traffic class.
// Depends on spq_pkg, spq_req_if, spq_rsp_if, spq_ram and assert_macros.svh.
//
// Usage:
//   Requests arrive on req_chan (valid/ready); each one gives exactly one result
//   on rsp_chan (valid/ready). Opcodes: enqueue, dequeue, peek, flush, clear
//   statistics. Dequeue and peek serve the highest non-empty class.
//   A request is taken in the idle state, and the descriptor memory is accessed in
//   that cycle; the result register is loaded in the done state that follows, once
//   the output register is free. A new request is taken only after the result of
//   the last one is loaded, since the result and the byte counter need the
//   registered read data of the descriptor memory.
//   When the receiver stalls, the result waits in the output register; one
//   more request may be taken and then holds until the register frees.
//   The APB-style port has the slot budget register at byte address 0. Writing
//   it empties all classes, keeping counters and peak; write only when idle.
//   Reset empties all classes, zeroes counters and peak and sets the capacity
//   to 256. No clearing pass runs: only occupied slots are ever read.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module strict_priority_packet_queue #(
   parameter int TOTAL_SLOTS = spq_pkg::TOTAL_SLOTS_DEF,
   parameter int HANDLE_BITS = spq_pkg::HANDLE_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   spq_req_if.sink     req_chan,
   spq_rsp_if.source   rsp_chan,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import spq_pkg::*;

   localparam int ADDR_BITS = $clog2(TOTAL_SLOTS);
   localparam int SLOT_BITS = HANDLE_BITS + BYTES_BITS;
   localparam int MAX_CAP   = (TOTAL_SLOTS > 511) ? 511 : TOTAL_SLOTS;
   localparam int BASE [CLASS_COUNT] = '{0, TOTAL_SLOTS / 8, TOTAL_SLOTS / 8 + TOTAL_SLOTS / 4,
                                         TOTAL_SLOTS / 8 + TOTAL_SLOTS / 2};

   // State registers.
   state_type                  state_ff, state_in;
   logic [CAP_BITS-1:0]        total_ff, total_in;
   logic [COUNT_BITS-1:0]      count_ff [CLASS_COUNT];
   logic [COUNT_BITS-1:0]      count_in [CLASS_COUNT];
   logic [COUNT_BITS-1:0]      head_ff  [CLASS_COUNT];
   logic [COUNT_BITS-1:0]      head_in  [CLASS_COUNT];
   logic [COUNT_BITS-1:0]      tail_ff  [CLASS_COUNT];
   logic [COUNT_BITS-1:0]      tail_in  [CLASS_COUNT];
   logic [CAP_BITS-1:0]        size_ff, size_in;
   logic [CAP_BITS-1:0]        peak_ff, peak_in;
   logic [STAT_BITS-1:0]       enq_cnt_ff, enq_cnt_in;
   logic [STAT_BITS-1:0]       deq_cnt_ff, deq_cnt_in;
   logic [STAT_BITS-1:0]       drop_cnt_ff, drop_cnt_in;
   logic [STAT_BITS-1:0]       bin_ff, bin_in;
   logic [STAT_BITS-1:0]       bout_ff, bout_in;

   // Request held between acceptance and completion.
   logic [OPCODE_BITS-1:0]     op_ff, op_in;
   logic [CLASS_BITS-1:0]      sel_ff, sel_in;
   logic                       go_ff, go_in;
   logic [COUNT_BITS-1:0]      ptr_next_ff, ptr_next_in;
   logic [COUNT_BITS-1:0]      cnt_next_ff, cnt_next_in;
   logic [BYTES_BITS-1:0]      bytes_ff, bytes_in;

   // Result register.
   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       rsp_ok_ff, rsp_ok_in;
   logic [HANDLE_BITS-1:0]     rsp_handle_ff, rsp_handle_in;
   logic [CLASS_BITS-1:0]      rsp_prio_ff, rsp_prio_in;
   logic [BYTES_BITS-1:0]      rsp_bytes_ff, rsp_bytes_in;
   logic                       rsp_full_ff, rsp_full_in;

   // Combinational signals.
   logic [CAP_BITS-1:0]        eff_total;
   logic [CAP_BITS+1:0]        triple_total;
   logic [COUNT_BITS-1:0]      cap [CLASS_COUNT];
   logic                       accept;
   logic                       cfg_write;
   logic                       done_fire;
   logic                       hit;
   logic [CLASS_BITS-1:0]      top_class;
   logic [CLASS_BITS-1:0]      sel;
   logic [COUNT_BITS-1:0]      cnt_sel;
   logic [COUNT_BITS-1:0]      ptr_sel;
   logic [COUNT_BITS-1:0]      ptr_inc;
   logic                       is_enq;
   logic                       is_read;
   logic                       enq_ok;
   logic [ADDR_BITS-1:0]       slot_addr;
   logic                       ram_wr_en;
   logic                       ram_rd_en;
   logic [SLOT_BITS-1:0]       ram_rd_data;
   logic                       full_now;

   // Class capacities from the saturated total: 1/8, 1/4, 1/4 and 3/8.
   always_comb begin
      eff_total = (total_ff > CAP_BITS'(MAX_CAP)) ? CAP_BITS'(MAX_CAP) : total_ff;
      triple_total = {2'b00, eff_total} + {1'b0, eff_total, 1'b0};
      cap[0] = COUNT_BITS'(eff_total >> 3);
      cap[1] = COUNT_BITS'(eff_total >> 2);
      cap[2] = COUNT_BITS'(eff_total >> 2);
      cap[3] = COUNT_BITS'(triple_total >> 3);
   end

   assign accept    = req_chan.valid && req_chan.ready;
   assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == CSR_SLOT_BUDGET);
   assign done_fire = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = (state_ff == ST_IDLE);

   // Highest non-empty class.
   always_comb begin
      hit = 1'b1;
      priority if (count_ff[3] != '0) begin
         top_class = 2'd3;
      end else if (count_ff[2] != '0) begin
         top_class = 2'd2;
      end else if (count_ff[1] != '0) begin
         top_class = 2'd1;
      end else begin
         top_class = 2'd0;
         hit = (count_ff[0] != '0);
      end
   end

   // Class and slot addressed by the request being accepted.
   always_comb begin
      is_enq    = (req_chan.opcode == OP_ENQUEUE);
      is_read   = (req_chan.opcode == OP_DEQUEUE) || (req_chan.opcode == OP_PEEK);
      sel       = is_enq ? req_chan.priority_req : top_class;
      cnt_sel   = count_ff[sel];
      ptr_sel   = is_enq ? tail_ff[sel] : head_ff[sel];
      ptr_inc   = ptr_sel + COUNT_BITS'(1);
      enq_ok    = (cnt_sel < cap[sel]);
      slot_addr = ADDR_BITS'(BASE[sel]) + ADDR_BITS'(ptr_sel);
      ram_wr_en = accept && is_enq && enq_ok;
      ram_rd_en = accept && is_read && hit;
   end

   // Descriptor store: handle and payload length per slot.
   spq_ram #(
      .WIDTH (SLOT_BITS),
      .DEPTH (TOTAL_SLOTS)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (slot_addr),
      .wr_data ({req_chan.packet_handle, req_chan.payload_bytes}),
      .rd_en   (ram_rd_en),
      .rd_addr (slot_addr),
      .rd_data (ram_rd_data)
   );

   // Capture the request and its precomputed pointer and count updates.
   always_comb begin
      op_in       = op_ff;
      sel_in      = sel_ff;
      go_in       = go_ff;
      ptr_next_in = ptr_next_ff;
      cnt_next_in = cnt_next_ff;
      bytes_in    = bytes_ff;
      if (accept) begin
         op_in       = req_chan.opcode;
         sel_in      = sel;
         go_in       = is_enq ? enq_ok : hit;
         ptr_next_in = (ptr_inc == cap[sel]) ? '0 : ptr_inc;
         cnt_next_in = is_enq ? (cnt_sel + COUNT_BITS'(1)) : (cnt_sel - COUNT_BITS'(1));
         bytes_in    = req_chan.payload_bytes;
      end
   end

   // Completion: apply the operation and form the result.
   always_comb begin
      state_in      = state_ff;
      total_in      = total_ff;
      count_in      = count_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      size_in       = size_ff;
      peak_in       = peak_ff;
      enq_cnt_in    = enq_cnt_ff;
      deq_cnt_in    = deq_cnt_ff;
      drop_cnt_in   = drop_cnt_ff;
      bin_in        = bin_ff;
      bout_in       = bout_ff;
      rsp_ok_in     = rsp_ok_ff;
      rsp_handle_in = rsp_handle_ff;
      rsp_prio_in   = rsp_prio_ff;
      rsp_bytes_in  = rsp_bytes_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;

      if (accept) begin
         state_in = ST_DONE;
      end

      if (done_fire) begin
         state_in      = ST_IDLE;
         rsp_valid_in  = 1'b1;
         rsp_ok_in     = 1'b0;
         rsp_handle_in = '0;
         rsp_prio_in   = '0;
         rsp_bytes_in  = '0;
         unique case (op_ff)
            OP_ENQUEUE: begin
               if (go_ff) begin
                  tail_in[sel_ff]  = ptr_next_ff;
                  count_in[sel_ff] = cnt_next_ff;
                  size_in          = size_ff + CAP_BITS'(1);
                  if (size_in > peak_ff) begin
                     peak_in = size_in;
                  end
                  enq_cnt_in = enq_cnt_ff + STAT_BITS'(1);
                  bin_in     = bin_ff + STAT_BITS'(bytes_ff);
                  rsp_ok_in  = 1'b1;
               end else begin
                  drop_cnt_in = drop_cnt_ff + STAT_BITS'(1);
               end
            end
            OP_DEQUEUE, OP_PEEK: begin
               if (go_ff) begin
                  rsp_ok_in     = 1'b1;
                  rsp_handle_in = ram_rd_data[SLOT_BITS-1:BYTES_BITS];
                  rsp_bytes_in  = ram_rd_data[BYTES_BITS-1:0];
                  rsp_prio_in   = sel_ff;
                  if (op_ff == OP_DEQUEUE) begin
                     head_in[sel_ff]  = ptr_next_ff;
                     count_in[sel_ff] = cnt_next_ff;
                     if (size_ff != '0) begin
                        size_in = size_ff - CAP_BITS'(1);
                     end
                     deq_cnt_in = deq_cnt_ff + STAT_BITS'(1);
                     bout_in    = bout_ff + STAT_BITS'(ram_rd_data[BYTES_BITS-1:0]);
                  end
               end
            end
            OP_FLUSH: begin
               for (int k = 0; k < CLASS_COUNT; k++) begin
                  count_in[k] = '0;
                  head_in[k]  = '0;
                  tail_in[k]  = '0;
               end
               size_in = '0;
            end
            OP_CLEAR: begin
               enq_cnt_in  = '0;
               deq_cnt_in  = '0;
               drop_cnt_in = '0;
               bin_in      = '0;
               bout_in     = '0;
               peak_in     = '0;
            end
            default: begin
            end
         endcase
      end

      // A capacity write empties every class, as a flush does.
      if (cfg_write) begin
         total_in = pwdata[CAP_BITS-1:0];
         for (int k = 0; k < CLASS_COUNT; k++) begin
            count_in[k] = '0;
            head_in[k]  = '0;
            tail_in[k]  = '0;
         end
         size_in = '0;
      end
   end

   // All classes at capacity after the operation; a zero-capacity class is full.
   always_comb begin
      full_now = 1'b1;
      for (int k = 0; k < CLASS_COUNT; k++) begin
         if (count_in[k] < cap[k]) begin
            full_now = 1'b0;
         end
      end
      rsp_full_in = done_fire ? full_now : rsp_full_ff;
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         total_ff     <= SLOT_BUDGET_RESET;
         size_ff      <= '0;
         peak_ff      <= '0;
         enq_cnt_ff   <= '0;
         deq_cnt_ff   <= '0;
         drop_cnt_ff  <= '0;
         bin_ff       <= '0;
         bout_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < CLASS_COUNT; k++) begin
            count_ff[k] <= '0;
            head_ff[k]  <= '0;
            tail_ff[k]  <= '0;
         end
      end else begin
         state_ff     <= state_in;
         total_ff     <= total_in;
         size_ff      <= size_in;
         peak_ff      <= peak_in;
         enq_cnt_ff   <= enq_cnt_in;
         deq_cnt_ff   <= deq_cnt_in;
         drop_cnt_ff  <= drop_cnt_in;
         bin_ff       <= bin_in;
         bout_ff      <= bout_in;
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      sel_ff        <= sel_in;
      go_ff         <= go_in;
      ptr_next_ff   <= ptr_next_in;
      cnt_next_ff   <= cnt_next_in;
      bytes_ff      <= bytes_in;
      rsp_ok_ff     <= rsp_ok_in;
      rsp_handle_ff <= rsp_handle_in;
      rsp_prio_ff   <= rsp_prio_in;
      rsp_bytes_ff  <= rsp_bytes_in;
      rsp_full_ff   <= rsp_full_in;
   end

   // Result channel. Counters and sizes are shown as they stand after the request.
   assign rsp_chan.valid             = rsp_valid_ff;
   assign rsp_chan.ok                = rsp_ok_ff;
   assign rsp_chan.out_handle        = rsp_handle_ff;
   assign rsp_chan.out_priority      = rsp_prio_ff;
   assign rsp_chan.out_payload_bytes = rsp_bytes_ff;
   assign rsp_chan.current_packets   = size_ff;
   assign rsp_chan.peak_packets      = peak_ff;
   assign rsp_chan.enqueued_count    = enq_cnt_ff;
   assign rsp_chan.dequeued_count    = deq_cnt_ff;
   assign rsp_chan.dropped_count     = drop_cnt_ff;
   assign rsp_chan.bytes_in          = bin_ff;
   assign rsp_chan.bytes_out         = bout_ff;
   assign rsp_chan.all_full          = rsp_full_ff;

   // Configuration read-back.
   assign pready = 1'b1;
   assign prdata = (paddr[2] == CSR_SLOT_BUDGET) ? {{(32 - CAP_BITS){1'b0}}, total_ff} : '0;

   // The total size tracks the per-class counts.
   `ASSERT_ALWAYS(a_size_sum, clock, reset, size_ff == (CAP_BITS'(count_ff[0]) + CAP_BITS'(count_ff[1]) + CAP_BITS'(count_ff[2]) + CAP_BITS'(count_ff[3])))
   // No class ever holds more than its capacity.
   `ASSERT_ALWAYS(a_count_cap, clock, reset, (count_ff[0] <= cap[0]) && (count_ff[1] <= cap[1]) && (count_ff[2] <= cap[2]) && (count_ff[3] <= cap[3]))
   // The descriptor memory is read only from an occupied class.
   `ASSERT_IMPLIES(a_read_occupied, clock, reset, ram_rd_en, cnt_sel != '0)

endmodule

// File: sim/spq_result_checker.sv
// Result checker for the strict priority packet queue: predicts one result per request.
// Depends on spq_pkg, spq_req_if and spq_rsp_if; watches the channels and the register port.
`timescale 1ns / 1ps

module spq_result_checker (
   input  logic        clock,
   input  logic        reset,
   spq_req_if          req_mon,
   spq_rsp_if          rsp_mon,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic        pready,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output int          mismatches,
   output int          pending,
   output int          checked
);
   import spq_pkg::*;

   localparam logic [2:0] CAPACITY_ADDR = {CSR_SLOT_BUDGET, 2'b00};

   typedef struct packed {
      logic                       ok;
      logic [HANDLE_BITS_DEF-1:0] handle;
      logic [CLASS_BITS-1:0]      cls;
      logic [BYTES_BITS-1:0]      nbytes;
      logic [CAP_BITS-1:0]        size_now;
      logic [CAP_BITS-1:0]        size_peak;
      logic [STAT_BITS-1:0]       enq_total;
      logic [STAT_BITS-1:0]       deq_total;
      logic [STAT_BITS-1:0]       drop_total;
      logic [STAT_BITS-1:0]       bytes_in_total;
      logic [STAT_BITS-1:0]       bytes_out_total;
      logic                       full;
   } request_result_type;

   // Predicted queue state: one ring per class, plus the size and the statistics.
   logic [CAP_BITS-1:0]        capacity_reg;
   logic [HANDLE_BITS_DEF-1:0] ring_handle [CLASS_COUNT][TOTAL_SLOTS_DEF];
   logic [BYTES_BITS-1:0]      ring_bytes  [CLASS_COUNT][TOTAL_SLOTS_DEF];
   int unsigned                head [CLASS_COUNT];
   int unsigned                fill [CLASS_COUNT];
   logic [CAP_BITS-1:0]        size_now;
   logic [CAP_BITS-1:0]        size_peak;
   logic [STAT_BITS-1:0]       enq_total;
   logic [STAT_BITS-1:0]       deq_total;
   logic [STAT_BITS-1:0]       drop_total;
   logic [STAT_BITS-1:0]       bytes_in_total;
   logic [STAT_BITS-1:0]       bytes_out_total;

   // Results still owed by the block, oldest first.
   request_result_type expected_results [$];

   // Slots of one class; totals above the slot count saturate.
   function automatic int unsigned class_capacity(input int unsigned cls);
      int unsigned total;
      total = (capacity_reg > TOTAL_SLOTS_DEF) ? TOTAL_SLOTS_DEF : capacity_reg;
      case (cls)
         0: return total / 8;
         1, 2: return total / 4;
         default: return total * 3 / 8;
      endcase
   endfunction

   function automatic void empty_classes();
      for (int k = 0; k < CLASS_COUNT; k++) begin
         head[k] = 0;
         fill[k] = 0;
      end
      size_now = '0;
   endfunction

   function automatic void clear_statistics();
      enq_total = '0;
      deq_total = '0;
      drop_total = '0;
      bytes_in_total = '0;
      bytes_out_total = '0;
      size_peak = '0;
   endfunction

   // Apply one request to the predicted state and return the result it should give.
   function automatic request_result_type predict_result(
      input logic [OPCODE_BITS-1:0]     opcode,
      input logic [HANDLE_BITS_DEF-1:0] handle,
      input logic [CLASS_BITS-1:0]      cls,
      input logic [BYTES_BITS-1:0]      nbytes
   );
      request_result_type r;
      int served;
      int unsigned slot;
      r = '0;
      served = -1;
      case (opcode)
         OP_ENQUEUE: begin
            if (fill[cls] < class_capacity(cls)) begin
               slot = (head[cls] + fill[cls]) % TOTAL_SLOTS_DEF;
               ring_handle[cls][slot] = handle;
               ring_bytes[cls][slot] = nbytes;
               fill[cls]++;
               size_now++;
               if (size_now > size_peak) size_peak = size_now;
               enq_total++;
               bytes_in_total += STAT_BITS'(nbytes);
               r.ok = 1'b1;
            end else begin
               // A full class, or one of zero slots, drops the packet.
               drop_total++;
            end
         end
         OP_DEQUEUE, OP_PEEK: begin
            // Strict priority: the highest class that holds a packet is served.
            for (int k = CLASS_COUNT - 1; k >= 0; k--) begin
               if (served < 0 && fill[k] != 0) served = k;
            end
            if (served >= 0) begin
               r.ok = 1'b1;
               r.handle = ring_handle[served][head[served]];
               r.nbytes = ring_bytes[served][head[served]];
               r.cls = CLASS_BITS'(served);
               if (opcode == OP_DEQUEUE) begin
                  head[served] = (head[served] + 1) % TOTAL_SLOTS_DEF;
                  fill[served]--;
                  size_now--;
                  deq_total++;
                  bytes_out_total += STAT_BITS'(r.nbytes);
               end
            end
         end
         OP_FLUSH: empty_classes();
         OP_CLEAR: clear_statistics();
         default: ;
      endcase
      r.size_now = size_now;
      r.size_peak = size_peak;
      r.enq_total = enq_total;
      r.deq_total = deq_total;
      r.drop_total = drop_total;
      r.bytes_in_total = bytes_in_total;
      r.bytes_out_total = bytes_out_total;
      // A class of zero slots counts as full.
      r.full = 1'b1;
      for (int k = 0; k < CLASS_COUNT; k++) begin
         if (fill[k] < class_capacity(k)) r.full = 1'b0;
      end
      return r;
   endfunction

   function automatic void compare_field(input string name, input logic [STAT_BITS-1:0] want,
                                         input logic [STAT_BITS-1:0] got);
      if (want !== got) begin
         mismatches++;
         $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
      end
   endfunction

   // Results are checked before new requests are predicted, since a result
   // always belongs to a request accepted at an earlier edge.
   always @(posedge clock) begin
      request_result_type want;
      if (reset) begin
         capacity_reg = SLOT_BUDGET_RESET;
         empty_classes();
         clear_statistics();
         expected_results.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            checked++;
            if (expected_results.size() == 0) begin
               mismatches++;
               $display("%0t: result with no request outstanding, expected none, got handle %0h",
                        $time, rsp_mon.out_handle);
            end else begin
               want = expected_results.pop_front();
               compare_field("ok", STAT_BITS'(want.ok), STAT_BITS'(rsp_mon.ok));
               compare_field("out_handle", STAT_BITS'(want.handle),
                             STAT_BITS'(rsp_mon.out_handle));
               compare_field("out_priority", STAT_BITS'(want.cls),
                             STAT_BITS'(rsp_mon.out_priority));
               compare_field("out_payload_bytes", STAT_BITS'(want.nbytes),
                             STAT_BITS'(rsp_mon.out_payload_bytes));
               compare_field("current_packets", STAT_BITS'(want.size_now),
                             STAT_BITS'(rsp_mon.current_packets));
               compare_field("peak_packets", STAT_BITS'(want.size_peak),
                             STAT_BITS'(rsp_mon.peak_packets));
               compare_field("enqueued_count", want.enq_total, rsp_mon.enqueued_count);
               compare_field("dequeued_count", want.deq_total, rsp_mon.dequeued_count);
               compare_field("dropped_count", want.drop_total, rsp_mon.dropped_count);
               compare_field("bytes_in", want.bytes_in_total, rsp_mon.bytes_in);
               compare_field("bytes_out", want.bytes_out_total, rsp_mon.bytes_out);
               compare_field("all_full", STAT_BITS'(want.full), STAT_BITS'(rsp_mon.all_full));
            end
         end
         // A capacity write empties every class but keeps counters and peak.
         if (psel && penable && pwrite && pready && paddr == CAPACITY_ADDR) begin
            capacity_reg = pwdata[CAP_BITS-1:0];
            empty_classes();
         end
         if (req_mon.valid && req_mon.ready)
            expected_results.push_back(predict_result(req_mon.opcode, req_mon.packet_handle,
                                                      req_mon.priority_req,
                                                      req_mon.payload_bytes));
      end
      pending = expected_results.size();
   end

endmodule

// File: sim/testbench.sv
// Top of the strict priority packet queue testbench: clock, reset, stimulus and verdict.
// Depends on spq_pkg, the channel interfaces, the queue RTL and spq_result_checker.
`timescale 1ns / 1ps

module testbench;
   import spq_pkg::*;

   localparam logic [2:0] CAPACITY_ADDR = {CSR_SLOT_BUDGET, 2'b00};
   localparam int CYCLE_LIMIT = 200000;
   localparam int SETTLE_CYCLES = 10;

   logic        clock;
   logic        reset;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [2:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   int mismatches;
   int pending;
   int checked;
   int sent;
   int capacity_writes;
   int cycles;
   int burst_left;

   spq_req_if req_chan ();
   spq_rsp_if rsp_chan ();

   strict_priority_packet_queue dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   spq_result_checker checker_inst (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_chan),
      .rsp_mon    (rsp_chan),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .pready     (pready),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .mismatches (mismatches),
      .pending    (pending),
      .checked    (checked)
   );

   // 2 ns clock.
   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   // Run limit, far above the slowest correct run.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("Run stopped after %0d cycles with %0d results still owed.", cycles, pending);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // The receiver switches between always ready, light stalls and heavy stalls.
   initial begin
      int stall_mode;
      int mode_left;
      stall_mode = 0;
      mode_left = 0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 2);
            mode_left = $urandom_range(8, 60);
         end
         mode_left--;
         case (stall_mode)
            0: rsp_chan.ready <= 1'b1;
            1: rsp_chan.ready <= ($urandom_range(0, 3) != 0);
            default: rsp_chan.ready <= ($urandom_range(0, 5) == 0);
         endcase
      end
   end

   // Sender pacing: bursts of random length separated by random gaps.
   task automatic pace_sender();
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
         if (gap != 0) begin
            req_chan.valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 12);
      end
      burst_left--;
   endtask

   // Present one request and hold it until the block takes it.
   task automatic issue_request(input logic [OPCODE_BITS-1:0] opcode,
                                input logic [HANDLE_BITS_DEF-1:0] handle,
                                input logic [CLASS_BITS-1:0] cls,
                                input logic [BYTES_BITS-1:0] nbytes);
      pace_sender();
      req_chan.valid <= 1'b1;
      req_chan.opcode <= opcode;
      req_chan.packet_handle <= handle;
      req_chan.priority_req <= cls;
      req_chan.payload_bytes <= nbytes;
      do @(posedge clock); while (!req_chan.ready);
      @(negedge clock);
      sent++;
   endtask

   // Stop sending and wait until every owed result has been taken.
   task automatic wait_idle();
      req_chan.valid <= 1'b0;
      burst_left = 0;
      while (pending != 0) @(negedge clock);
   endtask

   task automatic set_capacity(input int unsigned value);
      wait_idle();
      repeat (3) @(negedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= CAPACITY_ADDR;
      pwdata <= 32'(value);
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      capacity_writes++;
   endtask

   // Random mix of requests; enq_pct sets how hard the classes are filled.
   task automatic run_mix(input int count, input int enq_pct);
      int roll;
      logic [OPCODE_BITS-1:0] opcode;
      repeat (count) begin
         roll = $urandom_range(0, 99);
         if (roll < enq_pct) begin
            opcode = OP_ENQUEUE;
         end else begin
            roll = $urandom_range(0, 99);
            if (roll < 62) opcode = OP_DEQUEUE;
            else if (roll < 90) opcode = OP_PEEK;
            else if (roll < 94) opcode = OP_FLUSH;
            else if (roll < 97) opcode = OP_CLEAR;
            else opcode = OPCODE_BITS'($urandom_range(int'(OP_CLEAR) + 1, 7));
         end
         issue_request(opcode, HANDLE_BITS_DEF'($urandom), CLASS_BITS'($urandom),
                       BYTES_BITS'($urandom));
      end
   endtask

   initial begin
      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.opcode = OP_ENQUEUE;
      req_chan.packet_handle = '0;
      req_chan.priority_req = '0;
      req_chan.payload_bytes = '0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      cycles = 0;
      sent = 0;
      capacity_writes = 0;
      burst_left = 0;
      repeat (9) @(negedge clock);
      reset <= 1'b0;

      // Directed part at the reset capacity: misses on an empty queue, field
      // extremes, priority order, unknown opcodes, clear keeping the size, flush.
      issue_request(OP_DEQUEUE, 16'hFFFF, 2'd3, 16'hFFFF);
      issue_request(OP_PEEK, 16'hFFFF, 2'd3, 16'hFFFF);
      issue_request(OP_ENQUEUE, 16'h0000, 2'd0, 16'h0000);
      issue_request(OP_ENQUEUE, 16'hFFFF, 2'd3, 16'hFFFF);
      issue_request(OP_ENQUEUE, 16'h5555, 2'd1, 16'hAAAA);
      issue_request(OP_ENQUEUE, 16'hAAAA, 2'd2, 16'h5555);
      issue_request(OP_PEEK, 16'h0000, 2'd0, 16'h0000);
      repeat (5) issue_request(OP_DEQUEUE, 16'h0000, 2'd0, 16'h0000);
      for (int op = int'(OP_CLEAR) + 1; op < 8; op++)
         issue_request(OPCODE_BITS'(op), 16'h1111, 2'd1, 16'h2222);
      issue_request(OP_ENQUEUE, 16'h1234, 2'd2, 16'h8000);
      issue_request(OP_CLEAR, 16'h0000, 2'd0, 16'h0000);
      issue_request(OP_PEEK, 16'h0000, 2'd0, 16'h0000);
      issue_request(OP_FLUSH, 16'h0000, 2'd0, 16'h0000);
      issue_request(OP_PEEK, 16'h0000, 2'd0, 16'h0000);

      // Random phases over several capacities: zero, below eight, small ones that
      // fill up, values above the slot count, and the full size.
      run_mix(30, 55);
      set_capacity(0);
      run_mix(40, 50);
      set_capacity(5);
      run_mix(40, 70);
      set_capacity(8);
      run_mix(50, 70);
      set_capacity(40);
      run_mix(90, 75);
      set_capacity(511);
      run_mix(100, 85);
      set_capacity(300);
      run_mix(40, 50);
      set_capacity(256);
      run_mix(60, 40);
      set_capacity($urandom_range(0, 511));
      run_mix(60, 60);
      set_capacity($urandom_range(0, 511));
      run_mix(60, 60);
      set_capacity(13);
      run_mix(60, 70);

      wait_idle();
      repeat (SETTLE_CYCLES) @(negedge clock);
      $display("Sent %0d requests over %0d capacity settings, checked %0d results.",
               sent, capacity_writes + 1, checked);
      if (mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("%0d field mismatches seen.", mismatches);
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

// File: files.f
+incdir+rtl
rtl/spq_pkg.sv
rtl/spq_req_if.sv
rtl/spq_rsp_if.sv
rtl/spq_ram.sv
rtl/strict_priority_packet_queue.sv
sim/spq_result_checker.sv
sim/testbench.sv
